// ----- hdl/cll_pkg.sv -----
`default_nettype none
package cll_pkg;

	localparam int FIELD_BITS = 24;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);

	localparam logic [3:0] TK_IDENT  = 4'd0;
	localparam logic [3:0] TK_STRING = 4'd1;
	localparam logic [3:0] TK_NUMBER = 4'd2;
	localparam logic [3:0] TK_LBRACE = 4'd3;
	localparam logic [3:0] TK_RBRACE = 4'd4;
	localparam logic [3:0] TK_LPAREN = 4'd5;
	localparam logic [3:0] TK_RPAREN = 4'd6;
	localparam logic [3:0] TK_COLON  = 4'd7;
	localparam logic [3:0] TK_SEMI   = 4'd8;
	localparam logic [3:0] TK_COMMA  = 4'd9;
	localparam logic [3:0] TK_END    = 4'd10;
	localparam logic [3:0] TK_ERROR  = 4'd11;

	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	typedef enum logic [3:0] {
		M_IDLE,
		M_IDENT,
		M_NUMBER,
		M_STRING,
		M_SLASH,
		M_BLOCK,
		M_LINE,
		M_BSLASH,
		M_DOT
	} mode_t;

	typedef struct packed {
		logic [3:0]            kind;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] len;
		logic                  last;
	} token_t;

	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} push_t;

endpackage
`default_nettype wire

// ----- hdl/cll_front.sv -----
`default_nettype none
module cll_front import cll_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic                  kind,
	input  wire logic [7:0]            byte_req,
	output push_t                      push
);

	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [OFFSET_BITS-1:0] ONE     = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

	mode_t                  mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] ts_q, ts_d;
	logic                   dot_q, dot_d;
	logic                   esc_q, esc_d;
	logic                   star_q, star_d;

	function automatic logic [FIELD_BITS-1:0] fit(input logic [OFFSET_BITS-1:0] x);
		logic [OFFSET_BITS+FIELD_BITS-1:0] e;
		e = {{FIELD_BITS{1'b0}}, x};
		return e[FIELD_BITS-1:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic [3:0] punct_kind(input logic [7:0] c);
		logic [3:0] k;
		unique case (c)
			8'h7b:   k = TK_LBRACE;
			8'h7d:   k = TK_RBRACE;
			8'h28:   k = TK_LPAREN;
			8'h29:   k = TK_RPAREN;
			8'h3a:   k = TK_COLON;
			8'h3b:   k = TK_SEMI;
			8'h2c:   k = TK_COMMA;
			default: k = TK_ERROR;
		endcase
		return k;
	endfunction

	logic [OFFSET_BITS-1:0] diff;
	logic [OFFSET_BITS:0]   slen_w;
	logic [OFFSET_BITS-1:0] slen;
	logic                   ident_ch;
	mode_t                  f_mode;
	logic                   f_v;
	token_t                 f_tok;
	logic                   do_fresh;
	logic                   a_v, b_v;
	token_t                 a_t, b_t;

	assign diff     = pos_q - ts_q;
	assign slen_w   = {1'b0, diff} + {1'b0, ONE};
	assign slen     = slen_w[OFFSET_BITS] ? POS_MAX : slen_w[OFFSET_BITS-1:0];
	assign ident_ch = is_alpha(byte_req) || is_digit(byte_req) ||
		byte_req == CH_UNDER || byte_req == CH_DOT;

	// classification of the byte as the start of a new token
	always_comb begin
		f_v   = 1'b0;
		f_tok = '{kind: punct_kind(byte_req), start: fit(pos_q), len: fit(ONE), last: 1'b0};
		if (is_space(byte_req)) begin
			f_mode = M_IDLE;
		end else if (byte_req == CH_SLASH) begin
			f_mode = M_SLASH;
		end else if (byte_req == CH_BSLASH) begin
			f_mode = M_BSLASH;
		end else if (is_alpha(byte_req) || byte_req == CH_UNDER) begin
			f_mode = M_IDENT;
		end else if (is_digit(byte_req)) begin
			f_mode = M_NUMBER;
		end else if (byte_req == CH_DOT) begin
			f_mode = M_DOT;
		end else if (byte_req == CH_QUOTE) begin
			f_mode = M_STRING;
		end else begin
			f_mode = M_IDLE;
			f_v    = 1'b1;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		ts_d     = ts_q;
		dot_d    = dot_q;
		esc_d    = esc_q;
		star_d   = star_q;
		pos_d    = (pos_q == POS_MAX) ? pos_q : pos_q + ONE;
		do_fresh = 1'b0;
		a_v      = 1'b0;
		b_v      = 1'b0;
		a_t      = '{kind: TK_ERROR, start: fit(ts_q), len: fit(ONE), last: 1'b0};
		b_t      = a_t;
		if (kind) begin
			unique case (mode_q)
				M_IDENT: begin
					a_v      = 1'b1;
					a_t.kind = TK_IDENT;
					a_t.len  = fit(diff);
				end
				M_NUMBER: begin
					a_v      = 1'b1;
					a_t.kind = TK_NUMBER;
					a_t.len  = fit(diff);
				end
				M_STRING: begin
					a_v      = 1'b1;
					a_t.kind = TK_STRING;
					a_t.len  = fit(diff);
				end
				M_SLASH, M_BSLASH, M_DOT: a_v = 1'b1;
				default: ;
			endcase
			b_v = 1'b1;
			b_t = '{kind: TK_END, start: fit(pos_q), len: '0, last: 1'b0};
			mode_d = M_IDLE;
			pos_d  = '0;
			ts_d   = '0;
			dot_d  = 1'b0;
			esc_d  = 1'b0;
			star_d = 1'b0;
		end else begin
			unique case (mode_q)
				M_IDENT: begin
					if (!ident_ch) begin
						a_v      = 1'b1;
						a_t.kind = TK_IDENT;
						a_t.len  = fit(diff);
						do_fresh = 1'b1;
					end
				end
				M_NUMBER: begin
					if (byte_req == CH_DOT) begin
						if (dot_q) begin
							a_v     = 1'b1;
							a_t.len = fit(diff);
							mode_d  = M_DOT;
							ts_d    = pos_q;
						end else begin
							dot_d = 1'b1;
						end
					end else if (!is_digit(byte_req)) begin
						a_v      = 1'b1;
						a_t.kind = TK_NUMBER;
						a_t.len  = fit(diff);
						do_fresh = 1'b1;
					end
				end
				M_STRING: begin
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (byte_req == CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (byte_req == CH_QUOTE) begin
						a_v      = 1'b1;
						a_t.kind = TK_STRING;
						a_t.len  = fit(slen);
						mode_d   = M_IDLE;
					end
				end
				M_SLASH: begin
					if (byte_req == CH_STAR) begin
						mode_d = M_BLOCK;
						star_d = 1'b0;
					end else if (byte_req == CH_SLASH) begin
						mode_d = M_LINE;
					end else begin
						a_v      = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_BLOCK: begin
					if (star_q && byte_req == CH_SLASH) begin
						mode_d = M_IDLE;
					end else begin
						star_d = (byte_req == CH_STAR);
					end
				end
				M_LINE: begin
					if (byte_req == CH_LF) begin
						mode_d = M_IDLE;
					end
				end
				M_BSLASH: begin
					if (byte_req == CH_LF) begin
						mode_d = M_IDLE;
					end else begin
						a_v      = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(byte_req)) begin
						mode_d = M_NUMBER;
						dot_d  = 1'b1;
					end else begin
						a_v      = 1'b1;
						do_fresh = 1'b1;
					end
				end
				default: do_fresh = 1'b1;
			endcase
			if (do_fresh) begin
				mode_d = f_mode;
				ts_d   = pos_q;
				dot_d  = 1'b0;
				esc_d  = 1'b0;
				if (f_v) begin
					if (a_v) begin
						b_v = 1'b1;
						b_t = f_tok;
					end else begin
						a_v = 1'b1;
						a_t = f_tok;
					end
				end
			end
		end
		a_t.last = !b_v;
		b_t.last = 1'b1;
	end

	// end of buffer always yields the end token in slot b
	always_comb begin
		push.v0 = accept && (a_v || b_v);
		push.v1 = accept && a_v && b_v;
		push.t0 = a_v ? a_t : b_t;
		push.t1 = b_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			ts_q   <= '0;
			dot_q  <= 1'b0;
			esc_q  <= 1'b0;
			star_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			ts_q   <= ts_d;
			dot_q  <= dot_d;
			esc_q  <= esc_d;
			star_q <= star_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cll_queue.sv -----
`default_nettype none
module cll_queue import cll_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire push_t            push,
	input  wire logic             pop,
	output token_t                head,
	output logic                  nonempty,
	output logic                  room2
);

	token_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic [QPTR_BITS-1:0] wr1;
	logic [QPTR_BITS:0]   n_in;
	logic [QPTR_BITS:0]   n_out;

	assign wr1      = wr_q + {{(QPTR_BITS-1){1'b0}}, 1'b1};
	assign head     = mem_q[rd_q];
	assign nonempty = cnt_q != '0;
	assign room2    = cnt_q <= (QPTR_BITS+1)'(QDEPTH - 2);
	assign n_in     = {{QPTR_BITS{1'b0}}, push.v0} + {{QPTR_BITS{1'b0}}, push.v1};
	assign n_out    = {{QPTR_BITS{1'b0}}, pop};

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.t0;
		end
		if (push.v1) begin
			mem_q[wr1] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_in[QPTR_BITS-1:0];
			rd_q  <= rd_q + n_out[QPTR_BITS-1:0];
			cnt_q <= cnt_q + n_in - n_out;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cll_back.sv -----
`default_nettype none
module cll_back import cll_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire token_t                head,
	input  wire logic                  nonempty,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [3:0]                 token_kind,
	output logic [FIELD_BITS-1:0]      start_offset,
	output logic [FIELD_BITS-1:0]      token_length,
	output logic                       last_of_run
);

	logic   valid_q;
	token_t tok_q;

	assign pop          = nonempty && (!valid_q || !out_stall);
	assign out_valid    = valid_q;
	assign token_kind   = tok_q.kind;
	assign start_offset = tok_q.start;
	assign token_length = tok_q.len;
	assign last_of_run  = tok_q.last;

	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cell_library_text_lexer.sv -----
// A byte that completes a token writes it into the token queue; the output register then
// takes it. Throughput: one byte per cycle while in_stall is low; the output register
// delivers one token per cycle while out_stall is low, so the second token of a byte that
// emits two is absorbed by the four-entry token queue between lexer and output stage.
// Reset (arst_n low, asynchronous): lexer state, position, queue and output valid clear.
`default_nettype none
module cell_library_text_lexer import cll_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  kind,
	input  wire logic [7:0]            byte_req,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [3:0]                 token_kind,
	output logic [FIELD_BITS-1:0]      start_offset,
	output logic [FIELD_BITS-1:0]      token_length,
	output logic                       last_of_run
);

	push_t  push;
	token_t head;
	logic   nonempty;
	logic   room2;
	logic   pop;
	logic   accept;

	assign in_stall = !room2;
	assign accept   = in_valid && room2;

	cll_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (kind),
		.byte_req (byte_req),
		.push     (push)
	);

	cll_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty),
		.room2    (room2)
	);

	cll_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.nonempty     (nonempty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.start_offset (start_offset),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire

// ----- bench/cell_library_text_lexer_test.sv -----
`timescale 1ns / 1ps
module cell_library_text_lexer_test;
	import cll_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [7:0] byte_req = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] token_kind;
	logic [FIELD_BITS-1:0] start_offset;
	logic [FIELD_BITS-1:0] token_length;
	logic last_of_run;

	cell_library_text_lexer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.byte_req(byte_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// lexer state mirror
	mode_t mode;
	logic [23:0] pos;
	logic [23:0] tok_start;
	logic dot_seen;
	logic esc_pending;
	logic star_seen;
	token_t step_buf [0:1];
	int step_count;

	token_t pending_tokens[$];
	token_t got;
	logic [7:0] text_buf[$];

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int errors = 0;
	int items_sent = 0;
	int buffers_sent = 0;
	int tokens_checked = 0;

	string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
	string punct_chars = "{}():;,";

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
	endfunction

	function automatic logic [3:0] punct_token(input logic [7:0] c);
		case (c)
		8'h7b: return TK_LBRACE;
		8'h7d: return TK_RBRACE;
		8'h28: return TK_LPAREN;
		8'h29: return TK_RPAREN;
		8'h3a: return TK_COLON;
		8'h3b: return TK_SEMI;
		8'h2c: return TK_COMMA;
		default: return TK_ERROR;
		endcase
	endfunction

	task automatic clear_lexer();
		mode = M_IDLE;
		pos = '0;
		tok_start = '0;
		dot_seen = 1'b0;
		esc_pending = 1'b0;
		star_seen = 1'b0;
	endtask

	task automatic push_token(input logic [3:0] tk, input logic [23:0] start,
			input logic [24:0] len);
		if (step_count < 2) begin
			if (len > 25'h0ffffff)
				len = 25'h0ffffff;
			step_buf[step_count].kind = tk;
			step_buf[step_count].start = start;
			step_buf[step_count].len = len[23:0];
			step_buf[step_count].last = 1'b0;
			step_count++;
		end
	endtask

	task automatic lex_from_idle(input logic [7:0] c, input logic [23:0] p);
		mode = M_IDLE;
		if (!is_space(c)) begin
			tok_start = p;
			if (c == CH_SLASH)
				mode = M_SLASH;
			else if (c == CH_BSLASH)
				mode = M_BSLASH;
			else if (is_alpha(c) || c == CH_UNDER)
				mode = M_IDENT;
			else if (is_digit(c)) begin
				mode = M_NUMBER;
				dot_seen = 1'b0;
			end else if (c == CH_DOT)
				mode = M_DOT;
			else if (c == CH_QUOTE) begin
				mode = M_STRING;
				esc_pending = 1'b0;
			end else
				push_token(punct_token(c), p, 25'd1);
		end
	endtask

	// expected tokens for one accepted transaction
	task automatic lex_byte(input logic eob, input logic [7:0] c);
		logic [23:0] p;
		logic [24:0] span;
		p = pos;
		span = {1'b0, p} - {1'b0, tok_start};
		step_count = 0;
		if (eob) begin
			case (mode)
			M_IDENT: push_token(TK_IDENT, tok_start, span);
			M_NUMBER: push_token(TK_NUMBER, tok_start, span);
			M_STRING: push_token(TK_STRING, tok_start, span);
			M_SLASH, M_BSLASH, M_DOT: push_token(TK_ERROR, tok_start, 25'd1);
			default: ;
			endcase
			push_token(TK_END, p, 25'd0);
			clear_lexer();
		end else begin
			case (mode)
			M_IDENT: begin
				if (!is_ident_char(c)) begin
					push_token(TK_IDENT, tok_start, span);
					lex_from_idle(c, p);
				end
			end
			M_NUMBER: begin
				if (c == CH_DOT) begin
					if (dot_seen) begin
						push_token(TK_ERROR, tok_start, span);
						mode = M_DOT;
						tok_start = p;
					end else
						dot_seen = 1'b1;
				end else if (!is_digit(c)) begin
					push_token(TK_NUMBER, tok_start, span);
					lex_from_idle(c, p);
				end
			end
			M_STRING: begin
				if (esc_pending)
					esc_pending = 1'b0;
				else if (c == CH_BSLASH)
					esc_pending = 1'b1;
				else if (c == CH_QUOTE) begin
					push_token(TK_STRING, tok_start, span + 25'd1);
					mode = M_IDLE;
				end
			end
			M_SLASH: begin
				if (c == CH_STAR) begin
					mode = M_BLOCK;
					star_seen = 1'b0;
				end else if (c == CH_SLASH)
					mode = M_LINE;
				else begin
					push_token(TK_ERROR, tok_start, 25'd1);
					lex_from_idle(c, p);
				end
			end
			M_BLOCK: begin
				if (star_seen && c == CH_SLASH)
					mode = M_IDLE;
				else
					star_seen = (c == CH_STAR);
			end
			M_LINE: begin
				if (c == CH_LF)
					mode = M_IDLE;
			end
			M_BSLASH: begin
				if (c == CH_LF)
					mode = M_IDLE;
				else begin
					push_token(TK_ERROR, tok_start, 25'd1);
					lex_from_idle(c, p);
				end
			end
			M_DOT: begin
				if (is_digit(c)) begin
					mode = M_NUMBER;
					dot_seen = 1'b1;
				end else begin
					push_token(TK_ERROR, tok_start, 25'd1);
					lex_from_idle(c, p);
				end
			end
			default: lex_from_idle(c, p);
			endcase
			if (pos != 24'hffffff)
				pos = pos + 24'd1;
		end
		if (step_count > 0)
			step_buf[step_count - 1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			pending_tokens.insert(pending_tokens.size(), step_buf[i]);
	endtask

	// returns at the edge that accepts the transaction
	task automatic send_item(input logic eob, input logic [7:0] c);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= eob;
		byte_req <= c;
		do
			@(posedge clk);
		while (in_stall);
		lex_byte(eob, c);
		items_sent++;
		if (eob)
			buffers_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_tokens.size() != 0);
	endtask

	task automatic add_byte(input logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endtask

	task automatic add_fragment();
		int n;
		int sel;
		n = $urandom_range(0, 8);
		case ($urandom_range(0, 15))
		0, 1, 2: begin
			sel = $urandom_range(0, 52);
			add_byte(sel == 52 ? CH_UNDER : ident_chars[sel]);
			repeat (n) add_byte(ident_chars[$urandom_range(0, 63)]);
		end
		3, 4: begin
			if ($urandom_range(0, 3) == 0)
				add_byte(CH_DOT);
			repeat (n % 4 + 1) add_byte(8'(8'h30 + $urandom_range(0, 9)));
			if ($urandom_range(0, 1) == 1) begin
				add_byte(CH_DOT);
				repeat (n % 3) add_byte(8'(8'h30 + $urandom_range(0, 9)));
			end
			if ($urandom_range(0, 5) == 0) begin
				add_byte(CH_DOT);
				add_byte(8'(8'h30 + $urandom_range(0, 9)));
			end
		end
		5: begin
			add_byte(CH_QUOTE);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0)
					add_byte(CH_BSLASH);
				add_byte(8'($urandom_range(32, 126)));
			end
			if ($urandom_range(0, 6) != 0)
				add_byte(CH_QUOTE);
		end
		6, 7: repeat (n % 3 + 1) add_byte(punct_chars[$urandom_range(0, 6)]);
		8, 9: begin
			repeat (n % 3 + 1) begin
				sel = $urandom_range(8, 13);
				add_byte(sel == 8 ? 8'h20 : 8'(sel));
			end
		end
		10: begin
			add_byte(CH_SLASH);
			add_byte(CH_SLASH);
			repeat (n) add_byte(8'($urandom_range(32, 255)));
			add_byte(CH_LF);
		end
		11: begin
			add_byte(CH_SLASH);
			add_byte(CH_STAR);
			repeat (n) begin
				case ($urandom_range(0, 3))
				0: add_byte(CH_STAR);
				1: add_byte(CH_SLASH);
				2: add_byte(8'h61);
				default: add_byte(8'h20);
				endcase
			end
			if ($urandom_range(0, 5) != 0) begin
				add_byte(CH_STAR);
				add_byte(CH_SLASH);
			end
		end
		12: begin
			add_byte(CH_BSLASH);
			if ($urandom_range(0, 3) != 0)
				add_byte(CH_LF);
			else
				add_byte(8'($urandom_range(32, 126)));
		end
		13: add_byte($urandom_range(0, 1) == 1 ? CH_SLASH : CH_DOT);
		14: repeat (n % 3 + 1) add_byte(8'($urandom_range(0, 255)));
		default: add_byte(8'($urandom_range(128, 255)));
		endcase
	endtask

	task automatic send_random_buffer();
		int target;
		target = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40);
		text_buf.delete();
		while (text_buf.size() < target)
			add_fragment();
		foreach (text_buf[i])
			send_item(1'b0, text_buf[i]);
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// punctuation, lone slash, end byte ignored
	task automatic test_punctuation();
		send_text("{}():;,/x");
		send_item(1'b1, 8'ha5);
	endtask

	// second dot, lone dot, lone backslash, star of the opener, open string at end
	task automatic test_number_and_escape_errors();
		send_text("1.2.\\ /*/*/\"\\");
		send_item(1'b1, 8'h00);
	endtask

	// control and high bytes, open block comment at end
	task automatic test_odd_bytes();
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hff);
		send_item(1'b0, 8'h80);
		send_text("/*");
		send_item(1'b1, 8'hff);
	endtask

	task automatic test_random_text(input int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at)
			send_random_buffer();
	endtask

	// output held off while input keeps coming
	task automatic test_full_queue();
		int saved_gap;
		saved_gap = send_gap_pct;
		send_gap_pct = 0;
		hold_left = 80;
		send_text("{}():;,{}():;,{}():;,;;;");
		send_item(1'b1, 8'h3b);
		send_gap_pct = saved_gap;
	endtask

	// sender stops mid-buffer until everything is out
	task automatic test_pause_for_drain();
		send_text("abc 12");
		wait_drained();
		send_text("3 ;");
		send_item(1'b1, 8'h00);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token kind %0d start %0d length %0d last %0d",
					$time, token_kind, start_offset, token_length, last_of_run);
				errors++;
			end else begin
				got = pending_tokens.pop_front();
				tokens_checked++;
				if (token_kind !== got.kind) begin
					$display("%0t: token_kind expected %0d actual %0d",
						$time, got.kind, token_kind);
					errors++;
				end
				if (start_offset !== got.start) begin
					$display("%0t: start_offset expected %0d actual %0d",
						$time, got.start, start_offset);
					errors++;
				end
				if (token_length !== got.len) begin
					$display("%0t: token_length expected %0d actual %0d",
						$time, got.len, token_length);
					errors++;
				end
				if (last_of_run !== got.last) begin
					$display("%0t: last_of_run expected %0d actual %0d",
						$time, got.last, last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("cell_library_text_lexer test failed");
		$finish;
	end

	initial begin
		clear_lexer();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 33;
		recv_stall_pct = 50;
		test_punctuation();
		test_number_and_escape_errors();
		test_odd_bytes();
		test_random_text(470);

		send_gap_pct = 50;
		recv_stall_pct = 33;
		test_full_queue();
		test_random_text(470);
		test_pause_for_drain();

		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_text(470);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Lexed %0d buffers (%0d transactions) under mixed input gaps and output stalls,",
			buffers_sent, items_sent);
		$display("checked %0d tokens with %0d field mismatches.", tokens_checked, errors);
		if (errors == 0)
			$display("cell_library_text_lexer test passed");
		else
			$display("cell_library_text_lexer test failed");
		$finish;
	end

endmodule
